### rtl/mbrp_pkg.sv
// Shared types and constants for the multibulk request parser.
package mbrp_pkg;

	localparam int ByteW = 8;
	localparam int KindW = 2;
	localparam int CodeW = 3;
	localparam int ArgIdxW = 20;
	localparam int ArgCntW = 21;
	localparam int LenW = 30;
	localparam int HdrW = 17;
	localparam int CfgIdxW = 2;
	localparam int CfgDataW = 30;
	localparam int ProdW = LenW + 4;

	localparam logic [ArgCntW-1:0] HARD_MAX_ARGS = ArgCntW'(1048576);
	localparam logic [LenW-1:0] HARD_MAX_BULK = LenW'(536870912);
	localparam logic [HdrW-1:0] HDR_BYTES_RESET = HdrW'(65536);

	localparam logic [ByteW-1:0] CH_STAR = 8'h2a;
	localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;
	localparam logic [ByteW-1:0] CH_CR = 8'h0d;
	localparam logic [ByteW-1:0] CH_MINUS = 8'h2d;
	localparam logic [ByteW-1:0] CH_ZERO = 8'h30;
	localparam logic [ByteW-1:0] CH_NINE = 8'h39;

	localparam logic [CfgIdxW-1:0] REG_MAX_ARGS = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_MAX_BULK = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_HDR = 2'd2;

	localparam logic [KindW-1:0] KIND_DATA = 2'd0;
	localparam logic [KindW-1:0] KIND_ARG = 2'd1;
	localparam logic [KindW-1:0] KIND_ERR = 2'd2;

	localparam logic [CodeW-1:0] ERR_INLINE = 3'd0;
	localparam logic [CodeW-1:0] ERR_BAD_COUNT = 3'd1;
	localparam logic [CodeW-1:0] ERR_NONPOS_COUNT = 3'd2;
	localparam logic [CodeW-1:0] ERR_NO_DOLLAR = 3'd3;
	localparam logic [CodeW-1:0] ERR_BAD_LENGTH = 3'd4;
	localparam logic [CodeW-1:0] ERR_HDR_LONG = 3'd5;

	typedef enum logic [3:0] {
		PH_STAR      = 4'd0,
		PH_COUNT     = 4'd1,
		PH_COUNT_LF  = 4'd2,
		PH_HDR_FIRST = 4'd3,
		PH_LEN       = 4'd4,
		PH_NODOLLAR  = 4'd5,
		PH_LEN_LF    = 4'd6,
		PH_PAYLOAD   = 4'd7,
		PH_TRAIL1    = 4'd8,
		PH_TRAIL2    = 4'd9
	} phase_t;

	typedef struct packed {
		logic bad;
		logic zero;
		logic digit;
		logic neg;
	} num_flags_t;

endpackage

### rtl/multibulk_request_parser.sv
// Byte-serial multibulk request parser with registered input and result stages.
//
// Usage: request bytes enter on the in_valid/in_ready channel, one byte per
// transaction. Each byte lands in an input register and is parsed from there
// once the result stage can advance; the payload byte, argument-complete or
// error result it causes, if any, is held in the output register and offered
// on out_valid/out_ready. Throughput is one byte per cycle while results are
// taken, set by the single parse step between the two registers.
// When the receiver stalls with a result pending, the input register holds
// one more byte and in_ready drops until the result is taken.
// The first protocol error is reported once; all later bytes are accepted and
// dropped until reset. Reset clears the parser to wait for a star header,
// empties both stages and sets the argument and bulk limits to their hard
// maxima. Configuration writes on cfg_we take effect at once and must be made
// only while the parser is idle; the block itself does not enforce this.
module multibulk_request_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [mbrp_pkg::ByteW-1:0]    in_byte,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mbrp_pkg::KindW-1:0]    kind,
	output logic [mbrp_pkg::ByteW-1:0]    data_byte,
	output logic [mbrp_pkg::ArgIdxW-1:0]  arg_index,
	output logic [mbrp_pkg::LenW-1:0]     arg_length,
	output logic                          last_arg,
	output logic [mbrp_pkg::CodeW-1:0]    error_code,
	input  logic                          cfg_we,
	input  logic [mbrp_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [mbrp_pkg::CfgDataW-1:0] cfg_wdata
);
	import mbrp_pkg::*;

	logic [ArgCntW-1:0] max_args_q;
	logic [LenW-1:0] max_bulk_q;
	logic [HdrW-1:0] max_hdr_q;

	logic valid_s1;
	logic [ByteW-1:0] byte_s1;
	logic advance;
	logic step;

	phase_t phase_q;
	phase_t phase_d;
	logic [LenW-1:0] accum_q;
	num_flags_t flags_q;
	logic [ArgCntW-1:0] args_rem_q;
	logic [ArgIdxW-1:0] cur_arg_q;
	logic [LenW-1:0] bulk_rem_q;
	logic [LenW-1:0] bulk_total_q;
	logic [HdrW-1:0] hdr_cnt_q;
	logic err_q;

	logic is_cr;
	logic is_minus;
	logic is_digit;
	logic [3:0] digit_val;
	logic [LenW-1:0] arg_limit;
	logic [LenW-1:0] bulk_limit;
	logic [LenW-1:0] limit;
	logic [LenW-1:0] limit_p1;
	logic [ProdW-1:0] product;
	logic [LenW-1:0] accum_take;
	num_flags_t flags_take;
	logic num_ok;
	logic cnt_bad;
	logic cnt_nonpos;
	logic len_bad;
	logic hdr_full;
	logic [LenW-1:0] bulk_dec;
	logic [ArgCntW-1:0] args_dec;
	logic fail;
	logic [CodeW-1:0] fail_code;

	logic res_valid;
	logic [KindW-1:0] res_kind;
	logic [ByteW-1:0] res_byte;
	logic [LenW-1:0] res_length;
	logic res_last;
	logic [CodeW-1:0] res_code;

	assign advance = !out_valid || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step = valid_s1 && advance && !err_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_args_q <= HARD_MAX_ARGS;
			max_bulk_q <= HARD_MAX_BULK;
			max_hdr_q <= HDR_BYTES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_ARGS: max_args_q <= cfg_wdata[ArgCntW-1:0];
				REG_MAX_BULK: max_bulk_q <= cfg_wdata[LenW-1:0];
				REG_MAX_HDR:  max_hdr_q <= cfg_wdata[HdrW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	assign is_cr = byte_s1 == CH_CR;
	assign is_minus = byte_s1 == CH_MINUS;
	assign is_digit = (byte_s1 >= CH_ZERO) && (byte_s1 <= CH_NINE);
	assign digit_val = byte_s1[3:0];

	assign arg_limit = LenW'((max_args_q > HARD_MAX_ARGS) ? HARD_MAX_ARGS : max_args_q);
	assign bulk_limit = (max_bulk_q > HARD_MAX_BULK) ? HARD_MAX_BULK : max_bulk_q;
	assign limit = (phase_q == PH_COUNT) ? arg_limit : bulk_limit;
	assign limit_p1 = limit + LenW'(1);
	assign product = ProdW'({accum_q, 3'b000}) + ProdW'({accum_q, 1'b0}) + ProdW'(digit_val);

	always_comb begin
		flags_take = flags_q;
		accum_take = accum_q;
		if (is_minus) begin
			if (flags_q.neg || flags_q.digit) begin
				flags_take.bad = 1'b1;
			end else begin
				flags_take.neg = 1'b1;
			end
		end else if (is_digit) begin
			if (flags_q.zero) begin
				flags_take.bad = 1'b1;
			end
			if (!flags_q.digit && digit_val == 4'd0) begin
				if (flags_q.neg) begin
					flags_take.bad = 1'b1;
				end else begin
					flags_take.zero = 1'b1;
				end
			end
			flags_take.digit = 1'b1;
			accum_take = (product > ProdW'(limit_p1)) ? limit_p1 : product[LenW-1:0];
		end else begin
			flags_take.bad = 1'b1;
		end
	end

	assign num_ok = !flags_q.bad && flags_q.digit;
	assign cnt_bad = !num_ok || (!flags_q.neg && accum_q > arg_limit);
	assign cnt_nonpos = flags_q.neg || accum_q == '0;
	assign len_bad = !num_ok || flags_q.neg || accum_q > bulk_limit;
	assign hdr_full = hdr_cnt_q >= max_hdr_q;
	assign bulk_dec = (bulk_rem_q != '0) ? bulk_rem_q - LenW'(1) : bulk_rem_q;
	assign args_dec = (args_rem_q != '0) ? args_rem_q - ArgCntW'(1) : args_rem_q;

	always_comb begin
		phase_d = phase_q;
		fail = 1'b0;
		fail_code = ERR_INLINE;
		unique case (phase_q)
			PH_STAR: begin
				if (byte_s1 != CH_STAR) begin
					fail = 1'b1;
					fail_code = ERR_INLINE;
				end else begin
					phase_d = PH_COUNT;
				end
			end
			PH_COUNT: begin
				if (is_cr) begin
					if (cnt_bad) begin
						fail = 1'b1;
						fail_code = ERR_BAD_COUNT;
					end else if (cnt_nonpos) begin
						fail = 1'b1;
						fail_code = ERR_NONPOS_COUNT;
					end else begin
						phase_d = PH_COUNT_LF;
					end
				end
			end
			PH_COUNT_LF: phase_d = PH_HDR_FIRST;
			PH_HDR_FIRST, PH_NODOLLAR: begin
				if (is_cr) begin
					fail = 1'b1;
					fail_code = ERR_NO_DOLLAR;
				end else if (hdr_full) begin
					fail = 1'b1;
					fail_code = ERR_HDR_LONG;
				end else if (phase_q == PH_HDR_FIRST) begin
					phase_d = (byte_s1 == CH_DOLLAR) ? PH_LEN : PH_NODOLLAR;
				end
			end
			PH_LEN: begin
				if (!is_cr) begin
					if (hdr_full) begin
						fail = 1'b1;
						fail_code = ERR_HDR_LONG;
					end
				end else if (len_bad) begin
					fail = 1'b1;
					fail_code = ERR_BAD_LENGTH;
				end else begin
					phase_d = PH_LEN_LF;
				end
			end
			PH_LEN_LF: phase_d = (bulk_rem_q == '0) ? PH_TRAIL1 : PH_PAYLOAD;
			PH_PAYLOAD: begin
				if (bulk_dec == '0) begin
					phase_d = PH_TRAIL1;
				end
			end
			PH_TRAIL1: phase_d = PH_TRAIL2;
			PH_TRAIL2: phase_d = (args_dec == '0) ? PH_STAR : PH_HDR_FIRST;
			default: phase_d = PH_STAR;
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res_kind = KIND_DATA;
		res_byte = '0;
		res_length = '0;
		res_last = 1'b0;
		res_code = ERR_INLINE;
		if (step) begin
			if (fail) begin
				res_valid = 1'b1;
				res_kind = KIND_ERR;
				res_code = fail_code;
			end else if (phase_q == PH_PAYLOAD) begin
				res_valid = 1'b1;
				res_kind = KIND_DATA;
				res_byte = byte_s1;
			end else if (phase_q == PH_TRAIL2) begin
				res_valid = 1'b1;
				res_kind = KIND_ARG;
				res_length = bulk_total_q;
				res_last = args_rem_q <= ArgCntW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_STAR;
			accum_q <= '0;
			flags_q <= '0;
			args_rem_q <= '0;
			cur_arg_q <= '0;
			bulk_rem_q <= '0;
			bulk_total_q <= '0;
			hdr_cnt_q <= '0;
			err_q <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			if (fail) begin
				err_q <= 1'b1;
			end else begin
				unique case (phase_q)
					PH_STAR: begin
						accum_q <= '0;
						flags_q <= '0;
					end
					PH_COUNT: begin
						if (!is_cr) begin
							accum_q <= accum_take;
							flags_q <= flags_take;
						end else begin
							args_rem_q <= accum_q[ArgCntW-1:0];
							cur_arg_q <= '0;
						end
					end
					PH_HDR_FIRST: begin
						hdr_cnt_q <= HdrW'(1);
						accum_q <= '0;
						flags_q <= '0;
					end
					PH_NODOLLAR: hdr_cnt_q <= hdr_cnt_q + HdrW'(1);
					PH_LEN: begin
						if (!is_cr) begin
							hdr_cnt_q <= hdr_cnt_q + HdrW'(1);
							accum_q <= accum_take;
							flags_q <= flags_take;
						end else begin
							bulk_total_q <= accum_q;
							bulk_rem_q <= accum_q;
							hdr_cnt_q <= '0;
						end
					end
					PH_PAYLOAD: bulk_rem_q <= bulk_dec;
					PH_TRAIL2: begin
						args_rem_q <= args_dec;
						cur_arg_q <= (args_dec == '0) ? '0 : cur_arg_q + ArgIdxW'(1);
						bulk_total_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			kind <= res_kind;
			data_byte <= res_byte;
			arg_index <= cur_arg_q;
			arg_length <= res_length;
			last_arg <= res_last;
			error_code <= res_code;
		end
	end

endmodule

### sim/tb_multibulk_request_parser.sv
// Self-checking testbench for the multibulk request parser byte stream.
module tb_multibulk_request_parser;
	timeunit 1ns;
	timeprecision 1ps;

	import mbrp_pkg::*;

	localparam int QuietLimit = 2000;
	localparam int HoldCycles = 80;

	typedef struct packed {
		logic [KindW-1:0]   kind;
		logic [ByteW-1:0]   data_byte;
		logic [ArgIdxW-1:0] arg_index;
		logic [LenW-1:0]    arg_length;
		logic               last_arg;
		logic [CodeW-1:0]   error_code;
	} parse_token_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_PERIODIC
	} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [ByteW-1:0]    in_byte = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [KindW-1:0]    kind;
	logic [ByteW-1:0]    data_byte;
	logic [ArgIdxW-1:0]  arg_index;
	logic [LenW-1:0]     arg_length;
	logic                last_arg;
	logic [CodeW-1:0]    error_code;
	logic                cfg_we = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = REG_MAX_ARGS;
	logic [CfgDataW-1:0] cfg_wdata = '0;

	// Parser state as the stream should leave it.
	logic [ArgCntW-1:0] lim_args = HARD_MAX_ARGS;
	logic [LenW-1:0]    lim_bulk = HARD_MAX_BULK;
	logic [HdrW-1:0]    lim_hdr = HDR_BYTES_RESET;
	phase_t             ps_phase = PH_STAR;
	logic [LenW-1:0]    ps_acc = '0;
	num_flags_t         ps_flags = '0;
	logic [ArgCntW-1:0] ps_args_left = '0;
	logic [ArgIdxW-1:0] ps_arg = '0;
	logic [LenW-1:0]    ps_bulk_left = '0;
	logic [LenW-1:0]    ps_bulk_len = '0;
	logic [HdrW-1:0]    ps_hdr = '0;
	bit                 ps_dead = 1'b0;

	logic [ByteW-1:0] stream_bytes[$];
	parse_token_t     pending_tokens[$];

	bit       in_taken = 1'b0;
	int       burst_left = 1;
	int       gap_left = 0;
	bit       hold_req = 1'b0;
	int       hold_left = 0;
	int       rx_tick = 0;
	rx_mode_t rx_mode = RX_OPEN;
	int       quiet_cycles = 0;

	int               bytes_pushed = 0;
	int               bytes_taken = 0;
	int               data_seen = 0;
	int               args_seen = 0;
	int               commands_sent = 0;
	int               cfg_writes = 0;
	int               fails = 0;
	logic [CodeW-1:0] fault_seen = '0;

	multibulk_request_parser dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.kind      (kind),
		.data_byte (data_byte),
		.arg_index (arg_index),
		.arg_length(arg_length),
		.last_arg  (last_arg),
		.error_code(error_code),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [ArgCntW-1:0] eff_args();
		return (lim_args > HARD_MAX_ARGS) ? HARD_MAX_ARGS : lim_args;
	endfunction

	function automatic logic [LenW-1:0] eff_bulk();
		return (lim_bulk > HARD_MAX_BULK) ? HARD_MAX_BULK : lim_bulk;
	endfunction

	function automatic void take_digit(input logic [ByteW-1:0] b,
			input logic [LenW-1:0] limit);
		logic [ProdW-1:0] v;
		if (b == CH_MINUS) begin
			if (ps_flags.neg || ps_flags.digit)
				ps_flags.bad = 1'b1;
			else
				ps_flags.neg = 1'b1;
		end else if (b >= CH_ZERO && b <= CH_NINE) begin
			if (ps_flags.zero)
				ps_flags.bad = 1'b1;
			if (!ps_flags.digit && b == CH_ZERO) begin
				if (ps_flags.neg)
					ps_flags.bad = 1'b1;
				else
					ps_flags.zero = 1'b1;
			end
			ps_flags.digit = 1'b1;
			v = ProdW'(ps_acc) * ProdW'(10) + ProdW'(b - CH_ZERO);
			if (v > ProdW'(limit) + ProdW'(1))
				v = ProdW'(limit) + ProdW'(1);
			ps_acc = v[LenW-1:0];
		end else begin
			ps_flags.bad = 1'b1;
		end
	endfunction

	function automatic bit raise_error(inout parse_token_t tok, input logic [CodeW-1:0] code);
		ps_dead = 1'b1;
		tok.kind = KIND_ERR;
		tok.error_code = code;
		return 1'b1;
	endfunction

	// Advances the parser state by one byte; returns 1 when the byte yields a token.
	function automatic bit parse_byte(input logic [ByteW-1:0] b, output parse_token_t tok);
		tok = '0;
		tok.arg_index = ps_arg;
		if (ps_dead)
			return 1'b0;
		case (ps_phase)
		PH_STAR: begin
			if (b != CH_STAR)
				return raise_error(tok, ERR_INLINE);
			ps_acc = '0;
			ps_flags = '0;
			ps_phase = PH_COUNT;
		end
		PH_COUNT: begin
			if (b != CH_CR) begin
				take_digit(b, LenW'(eff_args()));
			end else if (ps_flags.bad || !ps_flags.digit ||
					(!ps_flags.neg && ps_acc > LenW'(eff_args()))) begin
				return raise_error(tok, ERR_BAD_COUNT);
			end else if (ps_flags.neg || ps_acc == '0) begin
				return raise_error(tok, ERR_NONPOS_COUNT);
			end else begin
				ps_args_left = ps_acc[ArgCntW-1:0];
				ps_arg = '0;
				ps_phase = PH_COUNT_LF;
			end
		end
		PH_COUNT_LF: ps_phase = PH_HDR_FIRST;
		PH_HDR_FIRST: begin
			if (b == CH_CR)
				return raise_error(tok, ERR_NO_DOLLAR);
			if (ps_hdr >= lim_hdr)
				return raise_error(tok, ERR_HDR_LONG);
			ps_hdr = HdrW'(1);
			ps_acc = '0;
			ps_flags = '0;
			ps_phase = (b == CH_DOLLAR) ? PH_LEN : PH_NODOLLAR;
		end
		PH_NODOLLAR: begin
			if (b == CH_CR)
				return raise_error(tok, ERR_NO_DOLLAR);
			if (ps_hdr >= lim_hdr)
				return raise_error(tok, ERR_HDR_LONG);
			ps_hdr = ps_hdr + HdrW'(1);
		end
		PH_LEN: begin
			if (b != CH_CR) begin
				if (ps_hdr >= lim_hdr)
					return raise_error(tok, ERR_HDR_LONG);
				ps_hdr = ps_hdr + HdrW'(1);
				take_digit(b, eff_bulk());
			end else if (ps_flags.bad || !ps_flags.digit || ps_flags.neg ||
					ps_acc > eff_bulk()) begin
				return raise_error(tok, ERR_BAD_LENGTH);
			end else begin
				ps_bulk_len = ps_acc;
				ps_bulk_left = ps_acc;
				ps_hdr = '0;
				ps_phase = PH_LEN_LF;
			end
		end
		PH_LEN_LF: ps_phase = (ps_bulk_left == '0) ? PH_TRAIL1 : PH_PAYLOAD;
		PH_PAYLOAD: begin
			tok.kind = KIND_DATA;
			tok.data_byte = b;
			if (ps_bulk_left != '0)
				ps_bulk_left = ps_bulk_left - LenW'(1);
			if (ps_bulk_left == '0)
				ps_phase = PH_TRAIL1;
			return 1'b1;
		end
		PH_TRAIL1: ps_phase = PH_TRAIL2;
		PH_TRAIL2: begin
			tok.kind = KIND_ARG;
			tok.arg_length = ps_bulk_len;
			tok.last_arg = (ps_args_left <= ArgCntW'(1));
			if (ps_args_left != '0)
				ps_args_left = ps_args_left - ArgCntW'(1);
			if (ps_args_left == '0) begin
				ps_arg = '0;
				ps_phase = PH_STAR;
			end else begin
				ps_arg = ps_arg + ArgIdxW'(1);
				ps_phase = PH_HDR_FIRST;
			end
			ps_bulk_len = '0;
			return 1'b1;
		end
		default: ps_phase = PH_STAR;
		endcase
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			fails++;
		end
	endtask

	function automatic logic [ByteW-1:0] rand_byte();
		return ByteW'($urandom_range(0, 255));
	endfunction

	task automatic push_byte(input logic [ByteW-1:0] b);
		stream_bytes.push_back(b);
		bytes_pushed++;
	endtask

	// Text, then CR, then the unchecked byte that follows it.
	task automatic push_line(input string s);
		foreach (s[i])
			push_byte(s[i]);
		push_byte(CH_CR);
		push_byte(rand_byte());
	endtask

	task automatic push_arg(input int len);
		push_byte(CH_DOLLAR);
		push_line($sformatf("%0d", len));
		repeat (len)
			push_byte(rand_byte());
		push_byte(rand_byte());
		push_byte(rand_byte());
	endtask

	task automatic push_command(input int nargs, input int lo, input int hi);
		push_byte(CH_STAR);
		push_line($sformatf("%0d", nargs));
		repeat (nargs)
			push_arg($urandom_range(lo, hi));
		commands_sent++;
	endtask

	task automatic run_commands(input int budget, input int max_args, input int max_len);
		int target;
		target = bytes_pushed + budget;
		while (bytes_pushed < target)
			push_command($urandom_range(1, max_args), 0, max_len);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
		REG_MAX_ARGS: lim_args = val[ArgCntW-1:0];
		REG_MAX_BULK: lim_bulk = val[LenW-1:0];
		REG_MAX_HDR: lim_hdr = val[HdrW-1:0];
		default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	// The sender holds off until the parser has drained, then the limits change.
	task automatic configure(input logic [CfgDataW-1:0] args_max,
			input logic [CfgDataW-1:0] bulk_max, input logic [CfgDataW-1:0] hdr_max);
		while (stream_bytes.size() != 0 || in_valid || pending_tokens.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		write_reg(REG_MAX_ARGS, args_max);
		write_reg(REG_MAX_BULK, bulk_max);
		write_reg(REG_MAX_HDR, hdr_max);
		@(posedge clk);
	endtask

	// The stream ends on one protocol error, since errors hold until reset.
	task automatic push_fault();
		int pick;
		logic [ByteW-1:0] b;
		string bad_counts[6] = '{"01", "", "-", "3x", "--1", "-0"};
		string nonpos_counts[3] = '{"0", "-5", "-99999999999"};
		string bad_lens[5] = '{"-1", "01", "-0", "", "1x"};
		pick = $urandom_range(0, 11);
		configure(CfgDataW'(3), CfgDataW'(50), CfgDataW'((pick == 11) ? 1 : 5));
		if (pick >= 5) begin
			push_byte(CH_STAR);
			push_line("3");
			if ($urandom_range(0, 1) == 1)
				push_arg($urandom_range(0, 9));
		end
		case (pick)
		0: begin
			b = rand_byte();
			if (b == CH_STAR)
				b = CH_DOLLAR;
			push_byte(b);
		end
		1: begin
			push_byte(CH_STAR);
			push_line(bad_counts[$urandom_range(0, 5)]);
		end
		2: begin
			push_byte(CH_STAR);
			push_line($sformatf("%0d", eff_args() + 1));
		end
		3: begin
			push_byte(CH_STAR);
			push_line("99999999999999");
		end
		4: begin
			push_byte(CH_STAR);
			push_line(nonpos_counts[$urandom_range(0, 2)]);
		end
		5: push_line("x12");
		6: push_line("");
		7: begin
			push_byte(CH_DOLLAR);
			push_line(bad_lens[$urandom_range(0, 4)]);
		end
		8: begin
			push_byte(CH_DOLLAR);
			push_line($sformatf("%0d", eff_bulk() + 1));
		end
		9: begin
			push_byte(CH_DOLLAR);
			push_line("123456");
		end
		10: push_line("abcdefgh");
		default: begin
			push_byte(CH_DOLLAR);
			push_line("0");
		end
		endcase
		repeat (16)
			push_byte(rand_byte());
	endtask

	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (gap_left != 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (stream_bytes.size() != 0) begin
				in_valid <= 1'b1;
				in_byte <= stream_bytes.pop_front();
				if (burst_left <= 1) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left--;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		rx_tick++;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HoldCycles;
			out_ready <= 1'b0;
		end else begin
			if (rx_tick % 128 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 3));
			case (rx_mode)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_MOSTLY: out_ready <= ($urandom_range(0, 4) != 0);
			default: out_ready <= (rx_tick % 7 > 2);
			endcase
		end
	end

	always @(posedge clk) begin
		parse_token_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_tokens.size() == 0) begin
					$error("unexpected result: kind %0d, arg_index %0d", kind, arg_index);
					fails++;
				end else begin
					want = pending_tokens.pop_front();
					check_field("kind", 32'(want.kind), 32'(kind));
					check_field("data_byte", 32'(want.data_byte), 32'(data_byte));
					check_field("arg_index", 32'(want.arg_index), 32'(arg_index));
					check_field("arg_length", 32'(want.arg_length), 32'(arg_length));
					check_field("last_arg", 32'(want.last_arg), 32'(last_arg));
					check_field("error_code", 32'(want.error_code), 32'(error_code));
				end
				if (kind == KIND_DATA)
					data_seen++;
				else if (kind == KIND_ARG)
					args_seen++;
				else
					fault_seen = error_code;
			end
			if (in_valid && in_ready) begin
				in_taken = 1'b1;
				bytes_taken++;
				if (parse_byte(in_byte, want))
					pending_tokens.push_back(want);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles == QuietLimit) begin
				$error("no transaction for %0d cycles, %0d results outstanding",
					QuietLimit, pending_tokens.size());
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Zero length argument, payload bytes at both extremes and protocol characters.
		push_byte(CH_STAR);
		push_line("2");
		push_byte(CH_DOLLAR);
		push_line("0");
		push_byte(rand_byte());
		push_byte(rand_byte());
		push_byte(CH_DOLLAR);
		push_line("4");
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(CH_CR);
		push_byte(CH_STAR);
		push_byte(rand_byte());
		push_byte(rand_byte());
		push_byte(CH_STAR);
		push_line("1");
		push_byte(CH_DOLLAR);
		push_line("1");
		push_byte(CH_MINUS);
		push_byte(rand_byte());
		push_byte(rand_byte());
		commands_sent += 2;

		configure(CfgDataW'(1), CfgDataW'(3), CfgDataW'(2));
		run_commands(100, 1, 3);

		configure(CfgDataW'(21'h1FFFFF), 30'h3FFFFFFF, CfgDataW'(17'h1FFFF));
		run_commands(100, 6, 24);
		while (stream_bytes.size() > 50)
			@(posedge clk);
		hold_req = 1'b1;

		configure(CfgDataW'(4), CfgDataW'(0), CfgDataW'(2));
		run_commands(80, 4, 0);

		configure(CfgDataW'(HARD_MAX_ARGS), HARD_MAX_BULK, CfgDataW'(HDR_BYTES_RESET));
		push_command(1, 150, 200);
		run_commands(100, 3, 40);

		configure(CfgDataW'(7), CfgDataW'(99), CfgDataW'(3));
		run_commands(100, 7, 40);

		push_fault();

		while (stream_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_tokens.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run: %0d bytes in %0d requests over %0d limit writes;",
			bytes_taken, commands_sent, cfg_writes);
		$display("%0d payload bytes and %0d arguments checked; closing error code %0d.",
			data_seen, args_seen, fault_seen);
		if (fails == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
